### rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Phase encoding, command codes and the state and result records that are
// shared by the step logic and the top level.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_WRST  = 3'd1;
    localparam logic [2:0] REQ_WRBY  = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;

    localparam int unsigned BITS_PER_BYTE = 8;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_ST3  = 5'd3,
        PH_ST4  = 5'd4,
        PH_TB_A = 5'd5,
        PH_TB_B = 5'd6,
        PH_TB_C = 5'd7,
        PH_AK_A = 5'd8,
        PH_AK_B = 5'd9,
        PH_AK_C = 5'd10,
        PH_RB_A = 5'd11,
        PH_RB_B = 5'd12,
        PH_RB_C = 5'd13,
        PH_MA_A = 5'd14,
        PH_MA_B = 5'd15,
        PH_MA_C = 5'd16,
        PH_SP1  = 5'd17,
        PH_SP2  = 5'd18,
        PH_SP3  = 5'd19,
        PH_SP4  = 5'd20
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] command;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] bytes_left;
        logic [7:0] addr_rw;
        logic       scl_out;
        logic       sda_out;
        logic       sda_enable;
    } state_t;

    typedef struct packed {
        logic       busy;
        logic       ack_valid;
        logic       ack_seen;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_IDLE,
        command:    REQ_TICK,
        bit_count:  4'd0,
        shift_reg:  8'd0,
        bytes_left: 8'd0,
        addr_rw:    8'd0,
        scl_out:    1'b1,
        sda_out:    1'b1,
        sda_enable: 1'b1
    };

endpackage

### rtl/i2cms_step.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer step logic
// Takes the sequencer state and one tick's request and sample, and gives the
// state after that tick's pin step together with the reported status.
// ----------------------------------------------------------------------------
module i2cms_step
    import i2cms_pkg::*;
(
    input  state_t     st,
    input  logic [2:0] req_type,
    input  logic [6:0] req_addr,
    input  logic [7:0] req_data,
    input  logic [7:0] req_len,
    input  logic       sda_sample,
    output state_t     nx,
    output result_t    res
);

    always_comb
    begin
        nx = st;

        if (st.phase == PH_IDLE && (req_type == REQ_WRST || req_type == REQ_WRBY ||
                                    req_type == REQ_READ || req_type == REQ_STOP))
        begin
            nx.command = req_type;
            priority if (req_type == REQ_WRST || req_type == REQ_READ)
            begin
                nx.addr_rw    = {req_addr, req_type == REQ_READ};
                nx.bytes_left = (req_type == REQ_READ) ? req_len : 8'd0;
                nx.phase      = PH_ST1;
            end
            else if (req_type == REQ_WRBY)
            begin
                nx.shift_reg  = req_data;
                nx.bit_count  = 4'd0;
                nx.bytes_left = 8'd0;
                nx.phase      = PH_TB_A;
            end
            else
            begin
                nx.phase = PH_SP1;
            end
        end

        unique case (nx.phase)
            PH_IDLE:
            begin
            end
            PH_ST1:
            begin
                nx.sda_out    = 1'b1;
                nx.sda_enable = 1'b1;
                nx.phase      = PH_ST2;
            end
            PH_ST2:
            begin
                nx.scl_out = 1'b1;
                nx.phase   = PH_ST3;
            end
            PH_ST3:
            begin
                nx.sda_out = 1'b0;
                nx.phase   = PH_ST4;
            end
            PH_ST4:
            begin
                nx.scl_out   = 1'b0;
                nx.shift_reg = nx.addr_rw;
                nx.bit_count = 4'd0;
                nx.phase     = PH_TB_A;
            end
            PH_TB_A:
            begin
                nx.scl_out    = 1'b0;
                nx.sda_enable = 1'b1;
                nx.sda_out    = nx.shift_reg[7];
                nx.phase      = PH_TB_B;
            end
            PH_TB_B:
            begin
                nx.scl_out = 1'b1;
                nx.phase   = PH_TB_C;
            end
            PH_TB_C:
            begin
                nx.scl_out   = 1'b0;
                nx.shift_reg = {nx.shift_reg[6:0], 1'b0};
                nx.bit_count = nx.bit_count + 4'd1;
                nx.phase     = (nx.bit_count >= 4'(BITS_PER_BYTE)) ? PH_AK_A : PH_TB_A;
            end
            PH_AK_A:
            begin
                nx.sda_enable = 1'b0;
                nx.phase      = PH_AK_B;
            end
            PH_AK_B:
            begin
                nx.scl_out = 1'b1;
                nx.phase   = PH_AK_C;
            end
            PH_AK_C:
            begin
                nx.scl_out    = 1'b0;
                nx.sda_enable = 1'b1;
                if (nx.command == REQ_READ && nx.bytes_left != 8'd0)
                begin
                    nx.shift_reg = 8'd0;
                    nx.bit_count = 4'd0;
                    nx.phase     = PH_RB_A;
                end
                else
                begin
                    nx.phase = PH_IDLE;
                end
            end
            PH_RB_A:
            begin
                nx.sda_enable = 1'b0;
                nx.scl_out    = 1'b0;
                nx.phase      = PH_RB_B;
            end
            PH_RB_B:
            begin
                nx.scl_out   = 1'b1;
                nx.shift_reg = {nx.shift_reg[6:0], sda_sample};
                nx.bit_count = nx.bit_count + 4'd1;
                nx.phase     = PH_RB_C;
            end
            PH_RB_C:
            begin
                nx.scl_out = 1'b0;
                nx.phase   = (nx.bit_count >= 4'(BITS_PER_BYTE)) ? PH_MA_A : PH_RB_A;
            end
            PH_MA_A:
            begin
                nx.sda_enable = 1'b1;
                nx.sda_out    = (nx.bytes_left == 8'd1);
                nx.phase      = PH_MA_B;
            end
            PH_MA_B:
            begin
                nx.scl_out = 1'b1;
                nx.phase   = PH_MA_C;
            end
            PH_MA_C:
            begin
                nx.scl_out    = 1'b0;
                nx.bytes_left = nx.bytes_left - 8'd1;
                if (nx.bytes_left == 8'd0)
                begin
                    nx.phase = PH_SP1;
                end
                else
                begin
                    nx.shift_reg = 8'd0;
                    nx.bit_count = 4'd0;
                    nx.phase     = PH_RB_A;
                end
            end
            PH_SP1:
            begin
                nx.scl_out = 1'b0;
                nx.phase   = PH_SP2;
            end
            PH_SP2:
            begin
                nx.sda_enable = 1'b1;
                nx.sda_out    = 1'b0;
                nx.phase      = PH_SP3;
            end
            PH_SP3:
            begin
                nx.scl_out = 1'b1;
                nx.phase   = PH_SP4;
            end
            PH_SP4:
            begin
                nx.sda_out = 1'b1;
                nx.phase   = PH_IDLE;
            end
            default:
            begin
                nx.phase = PH_IDLE;
            end
        endcase
    end

    // A command accepted while idle never starts in a sampling phase, so the
    // ack and receive status depend only on the phase held before this tick.
    always_comb
    begin
        res = '0;

        unique case (st.phase)
            PH_AK_B:
            begin
                res.ack_valid = 1'b1;
                res.ack_seen  = ~sda_sample;
            end
            PH_RB_B:
            begin
                if (st.bit_count + 4'd1 >= 4'(BITS_PER_BYTE))
                begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = {st.shift_reg[6:0], sda_sample};
                    res.rx_last  = (st.bytes_left == 8'd1);
                end
            end
            default:
            begin
            end
        endcase

        res.busy = (nx.phase != PH_IDLE);
    end

endmodule

### rtl/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Each input transaction is one bus tick carrying a command and the sampled
// SDA level; each output transaction gives the pin levels and the status
// that hold after that tick's step.
//
// The slave channel takes one transaction per tick: tuser carries the
// command code, tdata the address, write byte, read length and SDA sample.
// The master channel returns exactly one transaction per input transaction,
// in order, with tlast marking the last byte of a read transfer.
// A transaction goes through an input register and the step logic into an
// output register, which then offers its result.
// With the master side ready the block takes one transaction every cycle.
// When the receiver stalls, the output register holds its result, the
// input register holds the next transaction and tready drops once both are
// full; no transaction is lost. Reset empties both registers, returns the
// sequencer to idle and sets SCL and SDA high with SDA driven.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: req_addr[6:0], req_data[14:7], req_len[22:15], sda_sample[23].
    input  logic [23:0] s_axis_tdata,
    // Fields from bit 0: req_type[2:0].
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: scl_level, sda_level, sda_drive, busy_res, ack_valid,
    // ack_seen, rx_valid, rx_byte[14:7], zero padding[15].
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic        in_valid_reg;
    logic [23:0] in_data_reg;
    logic [2:0]  in_type_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     res;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    i2cms_step u_step
    (
        .st         (state_reg),
        .req_type   (in_type_reg),
        .req_addr   (in_data_reg[6:0]),
        .req_data   (in_data_reg[14:7]),
        .req_len    (in_data_reg[22:15]),
        .sda_sample (in_data_reg[23]),
        .nx         (state_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_type_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, res.rx_byte, res.rx_valid, res.ack_seen,
                             res.ack_valid, res.busy, state_next.sda_enable,
                             state_next.sda_out, state_next.scl_out};
            out_last_reg <= res.rx_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### tb/i2c_master_bit_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives one bus tick per input transaction and predicts the pin levels and
// status of every output transaction with a cycle model of the sequencer.
// Directed tests cover each command, the field extremes, slave NACK, write
// byte without START, commands while busy, unknown codes and a longer read.
// Random traffic then runs under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_test;
    import i2cms_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int END_LATENCY = 8;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       ack_valid;
        logic       ack_seen;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
    } pin_step_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    pin_step_t   expected_steps[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;

    phase_t      bus_phase = PH_IDLE;
    logic [2:0]  cur_cmd = REQ_TICK;
    logic [3:0]  bits_done = '0;
    logic [7:0]  shifter = '0;
    logic [7:0]  bytes_to_read = '0;
    logic [7:0]  addr_byte = '0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic        drive_q = 1'b1;

    i2c_master_bit_sequencer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pin_step_t step_bus(input logic [2:0] kind, input logic [6:0] addr,
                                           input logic [7:0] data, input logic [7:0] len,
                                           input logic smp);
        pin_step_t r;
        r = '0;
        if (bus_phase == PH_IDLE && kind >= REQ_WRST && kind <= REQ_STOP)
        begin
            cur_cmd = kind;
            if (kind == REQ_WRST || kind == REQ_READ)
            begin
                addr_byte = {addr, kind == REQ_READ};
                bytes_to_read = (kind == REQ_READ) ? len : 8'd0;
                bus_phase = PH_ST1;
            end
            else if (kind == REQ_WRBY)
            begin
                shifter = data;
                bits_done = '0;
                bytes_to_read = '0;
                bus_phase = PH_TB_A;
            end
            else
            begin
                bus_phase = PH_SP1;
            end
        end

        case (bus_phase)
            PH_IDLE: ;
            PH_ST1:
            begin
                sda_q = 1'b1;
                drive_q = 1'b1;
                bus_phase = PH_ST2;
            end
            PH_ST2:
            begin
                scl_q = 1'b1;
                bus_phase = PH_ST3;
            end
            PH_ST3:
            begin
                sda_q = 1'b0;
                bus_phase = PH_ST4;
            end
            PH_ST4:
            begin
                scl_q = 1'b0;
                shifter = addr_byte;
                bits_done = '0;
                bus_phase = PH_TB_A;
            end
            PH_TB_A:
            begin
                scl_q = 1'b0;
                drive_q = 1'b1;
                sda_q = shifter[7];
                bus_phase = PH_TB_B;
            end
            PH_TB_B:
            begin
                scl_q = 1'b1;
                bus_phase = PH_TB_C;
            end
            PH_TB_C:
            begin
                scl_q = 1'b0;
                shifter = {shifter[6:0], 1'b0};
                bits_done = bits_done + 4'd1;
                bus_phase = (bits_done >= 4'(BITS_PER_BYTE)) ? PH_AK_A : PH_TB_A;
            end
            PH_AK_A:
            begin
                drive_q = 1'b0;
                bus_phase = PH_AK_B;
            end
            PH_AK_B:
            begin
                scl_q = 1'b1;
                r.ack_valid = 1'b1;
                r.ack_seen = ~smp;
                bus_phase = PH_AK_C;
            end
            PH_AK_C:
            begin
                scl_q = 1'b0;
                drive_q = 1'b1;
                if (cur_cmd == REQ_READ && bytes_to_read != 8'd0)
                begin
                    shifter = '0;
                    bits_done = '0;
                    bus_phase = PH_RB_A;
                end
                else
                begin
                    bus_phase = PH_IDLE;
                end
            end
            PH_RB_A:
            begin
                drive_q = 1'b0;
                scl_q = 1'b0;
                bus_phase = PH_RB_B;
            end
            PH_RB_B:
            begin
                scl_q = 1'b1;
                shifter = {shifter[6:0], smp};
                bits_done = bits_done + 4'd1;
                if (bits_done >= 4'(BITS_PER_BYTE))
                begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = shifter;
                    r.rx_last = (bytes_to_read == 8'd1);
                end
                bus_phase = PH_RB_C;
            end
            PH_RB_C:
            begin
                scl_q = 1'b0;
                bus_phase = (bits_done >= 4'(BITS_PER_BYTE)) ? PH_MA_A : PH_RB_A;
            end
            PH_MA_A:
            begin
                drive_q = 1'b1;
                sda_q = (bytes_to_read == 8'd1);
                bus_phase = PH_MA_B;
            end
            PH_MA_B:
            begin
                scl_q = 1'b1;
                bus_phase = PH_MA_C;
            end
            PH_MA_C:
            begin
                scl_q = 1'b0;
                bytes_to_read = bytes_to_read - 8'd1;
                if (bytes_to_read == 8'd0)
                begin
                    bus_phase = PH_SP1;
                end
                else
                begin
                    shifter = '0;
                    bits_done = '0;
                    bus_phase = PH_RB_A;
                end
            end
            PH_SP1:
            begin
                scl_q = 1'b0;
                bus_phase = PH_SP2;
            end
            PH_SP2:
            begin
                drive_q = 1'b1;
                sda_q = 1'b0;
                bus_phase = PH_SP3;
            end
            PH_SP3:
            begin
                scl_q = 1'b1;
                bus_phase = PH_SP4;
            end
            PH_SP4:
            begin
                sda_q = 1'b1;
                bus_phase = PH_IDLE;
            end
            default: bus_phase = PH_IDLE;
        endcase

        r.scl = scl_q;
        r.sda = sda_q;
        r.drive = drive_q;
        r.busy = (bus_phase != PH_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        pin_step_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (expected_steps.size() == 0)
            begin
                report_mismatch("output transaction with nothing expected");
            end
            else
            begin
                want = expected_steps.pop_front();
                check_field("scl_level", 8'(m_axis_tdata[0]), 8'(want.scl));
                check_field("sda_level", 8'(m_axis_tdata[1]), 8'(want.sda));
                check_field("sda_drive", 8'(m_axis_tdata[2]), 8'(want.drive));
                check_field("busy_res", 8'(m_axis_tdata[3]), 8'(want.busy));
                check_field("ack_valid", 8'(m_axis_tdata[4]), 8'(want.ack_valid));
                check_field("ack_seen", 8'(m_axis_tdata[5]), 8'(want.ack_seen));
                check_field("rx_valid", 8'(m_axis_tdata[6]), 8'(want.rx_valid));
                check_field("rx_byte", m_axis_tdata[14:7], want.rx_byte);
                check_field("rx_last", 8'(m_axis_tlast), 8'(want.rx_last));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("i2c_master_bit_sequencer_top_test: errors");
        $finish;
    end

    task automatic send_tick(input logic [2:0] kind, input logic [6:0] addr,
                             input logic [7:0] data, input logic [7:0] len, input logic smp);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {smp, len, data, addr};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_steps.push_back(step_bus(kind, addr, data, len, smp));
    endtask

    task automatic finish_command(input logic ack_level);
        logic smp;
        while (bus_phase != PH_IDLE)
        begin
            smp = (bus_phase == PH_AK_B) ? ack_level : 1'($urandom_range(0, 1));
            send_tick(REQ_TICK, 7'($urandom), 8'($urandom), 8'($urandom), smp);
        end
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_steps.size() != 0) @(posedge clk);
    endtask

    task automatic test_idle_ticks;
        send_tick(REQ_TICK, 7'h00, 8'h00, 8'h00, 1'b0);
        send_tick(REQ_TICK, 7'h7F, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_unknown_codes;
        send_tick(3'd5, 7'h7F, 8'hFF, 8'hFF, 1'b1);
        send_tick(3'd6, 7'h2A, 8'h55, 8'h01, 1'b0);
        send_tick(3'd7, 7'h55, 8'hAA, 8'h80, 1'b1);
    endtask

    task automatic test_write_byte;
        send_tick(REQ_WRBY, 7'h00, 8'hFF, 8'h00, 1'b0);
        finish_command(1'b0);
        send_tick(REQ_WRBY, 7'h7F, 8'h00, 8'hFF, 1'b1);
        finish_command(1'b1);
    endtask

    task automatic test_write_start;
        send_tick(REQ_WRST, 7'h7F, 8'h00, 8'hFF, 1'b0);
        finish_command(1'b0);
        send_tick(REQ_WRBY, 7'h00, 8'hA5, 8'h00, 1'b0);
        finish_command(1'b0);
        send_tick(REQ_WRST, 7'h00, 8'hFF, 8'h00, 1'b1);
        finish_command(1'b1);
    endtask

    task automatic test_stop;
        send_tick(REQ_STOP, 7'h7F, 8'hFF, 8'hFF, 1'b1);
        finish_command(1'b0);
        send_tick(REQ_STOP, 7'h00, 8'h00, 8'h00, 1'b0);
        finish_command(1'b0);
    endtask

    task automatic test_read;
        send_tick(REQ_READ, 7'h55, 8'h00, 8'd0, 1'b0);
        finish_command(1'b0);
        send_tick(REQ_READ, 7'h2A, 8'hFF, 8'd1, 1'b0);
        finish_command(1'b0);
        send_tick(REQ_READ, 7'h7F, 8'h00, 8'd3, 1'b1);
        finish_command(1'b1);
    endtask

    task automatic test_busy_commands;
        logic [2:0] kind;
        send_tick(REQ_WRST, 7'h33, 8'h00, 8'h00, 1'b0);
        for (int k = 1; k < 8; k++)
        begin
            kind = 3'(k);
            send_tick(kind, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
        finish_command(1'b0);
        send_tick(REQ_READ, 7'h11, 8'h00, 8'd2, 1'b0);
        for (int k = 0; k < 40; k++)
        begin
            kind = 3'($urandom_range(1, 4));
            send_tick(kind, 7'($urandom), 8'($urandom), 8'hFF, 1'($urandom));
        end
        finish_command(1'b0);
    endtask

    task automatic test_long_read;
        send_tick(REQ_READ, 7'h7F, 8'h00, 8'd12, 1'b0);
        finish_command(1'b0);
    endtask

    task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
        logic [2:0] kind;
        logic [6:0] addr;
        logic [7:0] data;
        logic [7:0] len;
        logic       smp;
        int         pick;
        sender_idle_pct = snd_pct;
        recv_stall_pct = rcv_pct;
        for (int i = 0; i < count; i++)
        begin
            kind = REQ_TICK;
            addr = 7'($urandom);
            data = 8'($urandom);
            len = 8'($urandom);
            smp = 1'($urandom_range(0, 1));
            if (bus_phase == PH_IDLE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 27)
                    kind = REQ_WRST;
                else if (pick < 54)
                    kind = REQ_WRBY;
                else if (pick < 80)
                begin
                    kind = REQ_READ;
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        len = 8'($urandom_range(0, 3));
                    else if (pick < 97)
                        len = 8'($urandom_range(4, 12));
                    else
                        len = 8'($urandom_range(13, 40));
                end
                else if (pick < 90)
                    kind = REQ_STOP;
                else if (pick >= 95)
                    kind = 3'($urandom_range(5, 7));
            end
            else
            begin
                if ($urandom_range(0, 99) < 8)
                    kind = 3'($urandom_range(0, 7));
                if (bus_phase == PH_AK_B)
                    smp = ($urandom_range(0, 99) < 75) ? 1'b0 : 1'b1;
            end
            send_tick(kind, addr, data, len, smp);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_unknown_codes();
        test_write_byte();
        test_write_start();
        test_stop();
        test_read();
        test_busy_commands();
        drain_results();
        test_long_read();
        drain_results();

        test_random_traffic(215, 0, 0);
        test_random_traffic(215, 80, 0);
        test_random_traffic(215, 0, 80);
        test_random_traffic(215, 37, 37);

        repeat (END_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("i2c_master_bit_sequencer_top_test: clean");
        else
            $display("i2c_master_bit_sequencer_top_test: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/i2cms_pkg.sv
rtl/i2cms_step.sv
rtl/i2c_master_bit_sequencer_top.sv
tb/i2c_master_bit_sequencer_top_test.sv
